[sv/rkd_pkg.sv]
package rkd_pkg;

  // First candidate for the public exponent and the stride between candidates
  localparam int unsigned E_FIRST = 3;
  localparam int unsigned E_STEP  = 2;
  localparam int unsigned ONE     = 1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_N,
    CMD_MUL_PHI,
    CMD_ZERO_ALL,
    CMD_ZERO_KEYS,
    CMD_E_INIT,
    CMD_E_NEXT,
    CMD_G_LOAD,
    CMD_G_STEP,
    CMD_DIV_AB,
    CMD_DIV_EP,
    CMD_I_INIT,
    CMD_I_STEP,
    CMD_FIX
  } cmd_t;

  typedef struct packed {
    logic same;
    logic phi_small;
    logic busy;
    logic b_zero;
    logic a_one;
  } st_t;

endpackage

[sv/rkd_in_if.sv]
interface rkd_in_if #(
  parameter int PRIME_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [PRIME_WIDTH-1:0] prime_a;
  logic [PRIME_WIDTH-1:0] prime_b;

  modport source (output valid, output prime_a, output prime_b, input ready);
  modport sink   (input valid, input prime_a, input prime_b, output ready);
endinterface

[sv/rkd_out_if.sv]
interface rkd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] modulus;
  logic [31:0] totient;
  logic [31:0] public_exp;
  logic [31:0] private_exp;
  logic        same_primes;

  modport source (output valid, output modulus, output totient, output public_exp,
                  output private_exp, output same_primes, input ready);
  modport sink   (input valid, input modulus, input totient, input public_exp,
                  input private_exp, input same_primes, output ready);
endinterface

[sv/rsa_key_derivation.sv]
// channel   | dir | handshake     | payload
// in_chan   | in  | valid / ready | prime_a, prime_b (PRIME_WIDTH bits each)
// out_chan  | out | valid / ready | modulus, totient, public_exp, private_exp,
//           |     |               | same_primes
//
// One item at a time. An item first forms the two products, then makes one
// pass of the shared divider for every gcd or Euclid step; the time a key
// takes is set by the number of divider passes. Reset is synchronous and
// clears the controller and the divider busy flag only. The result holds on
// out_chan until taken; no new item is accepted until then.
module rsa_key_derivation import rkd_pkg::*; #(
  parameter int PRIME_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  rkd_in_if.sink   in_chan,
  rkd_out_if.source out_chan
);
  cmd_t cmd;
  st_t  st;

  // sequencer: drives the datapath one command a cycle
  rkd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // multiplier, divider with Euclid accumulator and the result registers
  rkd_datapath #(.PRIME_WIDTH(PRIME_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .prime_a     (in_chan.prime_a),
    .prime_b     (in_chan.prime_b),
    .st          (st),
    .modulus     (out_chan.modulus),
    .totient     (out_chan.totient),
    .public_exp  (out_chan.public_exp),
    .private_exp (out_chan.private_exp),
    .same_primes (out_chan.same_primes)
  );
endmodule

[sv/rkd_datapath.sv]
module rkd_datapath import rkd_pkg::*; #(
  parameter int PRIME_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  input  logic [PRIME_WIDTH-1:0] prime_a,
  input  logic [PRIME_WIDTH-1:0] prime_b,
  output st_t                    st,
  output logic [31:0]            modulus,
  output logic [31:0]            totient,
  output logic [31:0]            public_exp,
  output logic [31:0]            private_exp,
  output logic                   same_primes
);
  localparam int PW = 2 * PRIME_WIDTH;
  localparam int TW = PW + 2;
  localparam int CW = $clog2(PW);

  logic [PRIME_WIDTH-1:0] p_r, q_r, pm, qm, mul_a, mul_b;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          n_r, phi_r, e_r, d_r, a_r, b_r;
  logic                   same_r;
  logic signed [TW-1:0]   t0_r, t1_r, acc_r, t_sh, d_fix;
  logic [PW-1:0]          dvd_r, dvs_r, rem_r;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic [PW:0]            rem_sh, rem_sub;
  logic                   ge;

  assign pm = (p_r == '0) ? '0 : p_r - 1'b1;
  assign qm = (q_r == '0) ? '0 : q_r - 1'b1;

  // one shared multiplier: p*q, then (p-1)*(q-1)
  assign mul_a = (cmd == CMD_MUL_N) ? p_r : pm;
  assign mul_b = (cmd == CMD_MUL_N) ? q_r : qm;
  assign prod  = {{PRIME_WIDTH{1'b0}}, mul_a} * {{PRIME_WIDTH{1'b0}}, mul_b};

  // restoring divider, one quotient bit a cycle; the quotient bits also
  // drive a shift-add that forms t0 - quotient*t1 for extended Euclid
  assign rem_sh  = {rem_r, dvd_r[PW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign t_sh    = t1_r <<< cnt_r;
  assign d_fix   = t0_r[TW-1] ? t0_r + signed'({2'b00, phi_r}) : t0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd == CMD_DIV_AB || cmd == CMD_DIV_EP) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      rem_r <= ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
      if (ge) begin
        acc_r <= acc_r - t_sh;
      end
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r - 1'b1;
    end
    unique case (cmd)
      CMD_NONE: ;
      CMD_LOAD: begin
        p_r    <= prime_a;
        q_r    <= prime_b;
        same_r <= (prime_a == prime_b);
      end
      CMD_MUL_N:   n_r <= prod;
      CMD_MUL_PHI: phi_r <= prod;
      CMD_ZERO_ALL: begin
        n_r   <= '0;
        phi_r <= '0;
        e_r   <= '0;
        d_r   <= '0;
      end
      CMD_ZERO_KEYS: begin
        e_r <= '0;
        d_r <= '0;
      end
      CMD_E_INIT: e_r <= PW'(E_FIRST);
      CMD_E_NEXT: e_r <= e_r + PW'(E_STEP);
      CMD_G_LOAD: begin
        a_r <= e_r;
        b_r <= phi_r;
      end
      CMD_G_STEP: begin
        a_r <= b_r;
        b_r <= rem_r;
      end
      CMD_DIV_AB: begin
        dvd_r <= a_r;
        dvs_r <= b_r;
        rem_r <= '0;
        acc_r <= t0_r;
        cnt_r <= CW'(PW - 1);
      end
      CMD_DIV_EP: begin
        dvd_r <= e_r;
        dvs_r <= phi_r;
        rem_r <= '0;
        acc_r <= t0_r;
        cnt_r <= CW'(PW - 1);
      end
      CMD_I_INIT: begin
        a_r  <= phi_r;
        b_r  <= rem_r;
        t0_r <= '0;
        t1_r <= TW'(ONE);
      end
      CMD_I_STEP: begin
        a_r  <= b_r;
        b_r  <= rem_r;
        t0_r <= t1_r;
        t1_r <= acc_r;
      end
      CMD_FIX: d_r <= PW'(d_fix);
      default: ;
    endcase
  end

  assign st.same      = same_r;
  assign st.phi_small = phi_r < PW'(E_STEP);
  assign st.busy      = busy_r;
  assign st.b_zero    = (b_r == '0);
  assign st.a_one     = (a_r == PW'(ONE));

  assign modulus     = 32'(n_r);
  assign totient     = 32'(phi_r);
  assign public_exp  = 32'(e_r);
  assign private_exp = 32'(d_r);
  assign same_primes = same_r;
endmodule

[sv/rkd_ctrl.sv]
module rkd_ctrl import rkd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  st_t  st,
  output cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL_N, S_MUL_PHI, S_E_INIT, S_G_LOAD, S_G_DIV, S_G_WAIT, S_G_STEP,
    S_G_CHECK, S_I_MOD, S_I_MWAIT, S_I_CHECK, S_I_WAIT, S_I_STEP, S_FIX, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready_r) begin
        cmd       = CMD_LOAD;
        state_nxt = S_MUL_N;
      end
      S_MUL_N: begin
        if (st.same) begin
          cmd       = CMD_ZERO_ALL;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_MUL_N;
          state_nxt = S_MUL_PHI;
        end
      end
      S_MUL_PHI: begin
        cmd       = CMD_MUL_PHI;
        state_nxt = S_E_INIT;
      end
      S_E_INIT: begin
        if (st.phi_small) begin
          cmd       = CMD_ZERO_KEYS;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_E_INIT;
          state_nxt = S_G_LOAD;
        end
      end
      S_G_LOAD: begin
        cmd       = CMD_G_LOAD;
        state_nxt = S_G_DIV;
      end
      S_G_DIV: begin
        cmd       = CMD_DIV_AB;
        state_nxt = S_G_WAIT;
      end
      S_G_WAIT: if (!st.busy) state_nxt = S_G_STEP;
      S_G_STEP: begin
        cmd       = CMD_G_STEP;
        state_nxt = S_G_CHECK;
      end
      S_G_CHECK: begin
        priority if (!st.b_zero) begin
          state_nxt = S_G_DIV;
        end else if (st.a_one) begin
          state_nxt = S_I_MOD;
        end else begin
          cmd       = CMD_E_NEXT;
          state_nxt = S_G_LOAD;
        end
      end
      S_I_MOD: begin
        cmd       = CMD_DIV_EP;
        state_nxt = S_I_MWAIT;
      end
      S_I_MWAIT: if (!st.busy) begin
        cmd       = CMD_I_INIT;
        state_nxt = S_I_CHECK;
      end
      S_I_CHECK: begin
        if (st.b_zero) begin
          state_nxt = S_FIX;
        end else begin
          cmd       = CMD_DIV_AB;
          state_nxt = S_I_WAIT;
        end
      end
      S_I_WAIT: if (!st.busy) state_nxt = S_I_STEP;
      S_I_STEP: begin
        cmd       = CMD_I_STEP;
        state_nxt = S_I_CHECK;
      end
      S_FIX: begin
        cmd       = CMD_FIX;
        state_nxt = S_DONE;
      end
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= (state_nxt == S_DONE);
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
endmodule

[tb/sv/rkd_checker.sv]
`timescale 1ns / 1ps
module rkd_checker #(
  parameter int PRIME_WIDTH = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  rkd_in_if     in_chan,
  rkd_out_if    out_chan,
  output int    errors,
  output int    keys_pending
);

  typedef struct {
    logic [31:0] modulus;
    logic [31:0] totient;
    logic [31:0] public_exp;
    logic [31:0] private_exp;
    logic        same_primes;
  } rsa_key_t;

  rsa_key_t key_queue[$];
  int       err_cnt  = 0;
  int       pend_cnt = 0;

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic rsa_key_t derive_key(logic [PRIME_WIDTH-1:0] pa,
                                          logic [PRIME_WIDTH-1:0] pb);
    rsa_key_t k;
    longint unsigned p, q, phi, e, d;
    longint r0, r1, r2, t0, t1, t2, qt;
    p = pa;
    q = pb;
    k = '{default: '0};
    if (p == q) begin
      k.same_primes = 1'b1;
      return k;
    end
    phi = ((p > 0) ? p - 1 : 0) * ((q > 0) ? q - 1 : 0);
    e = 0;
    d = 0;
    if (phi >= 2) begin
      e = rkd_pkg::E_FIRST;
      while (gcd64(e, phi) != rkd_pkg::ONE) e += rkd_pkg::E_STEP;
      // extended Euclid, coefficient of e only
      r0 = phi;
      r1 = e % phi;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        qt = r0 / r1;
        r2 = r0 - qt * r1;
        t2 = t0 - qt * t1;
        r0 = r1; r1 = r2;
        t0 = t1; t1 = t2;
      end
      if (t0 < 0) t0 += phi;
      d = t0;
    end
    k.modulus     = 32'(p * q);
    k.totient     = 32'(phi);
    k.public_exp  = 32'(e);
    k.private_exp = 32'(d);
    return k;
  endfunction

  assign keys_pending = pend_cnt;
  assign errors       = err_cnt;

  always @(posedge clk) begin
    rsa_key_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        key_queue.push_back(derive_key(in_chan.prime_a, in_chan.prime_b));
      if (out_chan.valid && out_chan.ready) begin
        if (key_queue.size() == 0) begin
          $error("unexpected key item");
          err_cnt++;
        end else begin
          want = key_queue.pop_front();
          if (out_chan.modulus !== want.modulus) begin
            $error("modulus exp %0d got %0d", want.modulus, out_chan.modulus);
            err_cnt++;
          end
          if (out_chan.totient !== want.totient) begin
            $error("totient exp %0d got %0d", want.totient, out_chan.totient);
            err_cnt++;
          end
          if (out_chan.public_exp !== want.public_exp) begin
            $error("public_exp exp %0d got %0d", want.public_exp, out_chan.public_exp);
            err_cnt++;
          end
          if (out_chan.private_exp !== want.private_exp) begin
            $error("private_exp exp %0d got %0d", want.private_exp,
                   out_chan.private_exp);
            err_cnt++;
          end
          if (out_chan.same_primes !== want.same_primes) begin
            $error("same_primes exp %0b got %0b", want.same_primes,
                   out_chan.same_primes);
            err_cnt++;
          end
        end
      end
      pend_cnt = key_queue.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  localparam int PW        = 16;
  localparam int IDLE_MAX  = 200000;   // cycles with no item moving
  localparam int N_RANDOM  = 140;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors;
  int   keys_pending;
  int   idle_pct;   // sender gap odds, per hundred
  int   stall_pct;  // receiver stall odds, per hundred
  int   quiet_cycles = 0;
  bit   stim_done = 1'b0;

  rkd_in_if #(.PRIME_WIDTH(PW)) in_chan ();
  rkd_out_if out_chan ();

  rsa_key_derivation #(.PRIME_WIDTH(PW)) dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan)
  );

  rkd_checker #(.PRIME_WIDTH(PW)) checker_i (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .errors(errors), .keys_pending(keys_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Small primes and a few large ones; most keys stay fast to derive.
  int unsigned prime_pool[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
                                97, 101, 251, 257, 509, 1021, 4093, 8191,
                                32749, 65521, 65519, 65497};

  // Receiver: stall at the current odds, drawn afresh every cycle.
  initial out_chan.ready = 1'b0;
  always @(posedge clk)
    out_chan.ready <= ($urandom_range(99) >= stall_pct);

  // Watchdog: count cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Send one item, hold it until the block takes it, then drop valid for a
  // cycle; the block is busy then anyway.
  task automatic send_primes(int unsigned pa, int unsigned pb);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_chan.valid   <= 1'b1;
    in_chan.prime_a <= PW'(pa);
    in_chan.prime_b <= PW'(pb);
    do @(posedge clk); while (!in_chan.ready);
    in_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int unsigned pick_prime();
    int r;
    r = $urandom_range(99);
    if (r < 80) return prime_pool[$urandom_range(prime_pool.size() - 1)];
    if (r < 90) return $urandom_range(60);      // non-primes and tiny values
    return $urandom();                           // anything in the field
  endfunction

  initial begin
    int unsigned pa, pb;
    in_chan.valid   = 1'b0;
    in_chan.prime_a = '0;
    in_chan.prime_b = '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: equal factors, factors below two, degenerate totient, extremes.
    send_primes(3, 5);
    send_primes(7, 7);
    send_primes(0, 0);
    send_primes(0, 13);
    send_primes(1, 17);
    send_primes(2, 3);       // totient 2
    send_primes(2, 2);
    send_primes(1, 2);       // totient 0
    send_primes(65535, 65535);
    send_primes(65521, 65519);
    send_primes(65535, 65534);  // non-prime, all bits set
    send_primes(16'hAAAA, 16'h5555);
    send_primes(11, 13);     // e search steps past divisors of phi
    send_primes(31, 211);
    send_primes(4, 9);

    // Hold off until every key has come back.
    wait (keys_pending == 0);
    @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      case ((i * 4) / N_RANDOM)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      pa = pick_prime();
      pb = ($urandom_range(19) == 0) ? pa : pick_prime();
      send_primes(pa, pb);
    end

    stall_pct = 0;
    wait (keys_pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[rsa_key_derivation.f]
sv/rkd_pkg.sv
sv/rkd_in_if.sv
sv/rkd_out_if.sv
sv/rkd_datapath.sv
sv/rkd_ctrl.sv
sv/rsa_key_derivation.sv
tb/sv/rkd_checker.sv
tb/sv/tb_top.sv
